### rtl/core/fan_level_hysteresis_select_unit_defines.svh
// Assertion macros for the fan level hysteresis select unit.
// Used by the port checker; needs a clk and rst in scope.
`ifndef FAN_LEVEL_HYSTERESIS_SELECT_UNIT_DEFINES_SVH
`define FAN_LEVEL_HYSTERESIS_SELECT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FLHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FLHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked across reset as well.
`define FLHS_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/flhs_pkg.sv
// Shared types and constants for the fan level hysteresis select unit.
// No dependencies.
`timescale 1ns / 1ps

package flhs_pkg;

  // Table size and field widths
  localparam int LEVEL_COUNT = 8;
  localparam int REG_COUNT   = 8;
  localparam int ENTRY_W     = 30;
  localparam int DEMAND_W    = 7;
  localparam int SPEED_W     = 16;
  localparam int LEVEL_W     = 3;
  localparam int INDEX_W     = 3;
  localparam int CUR_W       = 4;

  // Packed entry layout
  localparam int ON_LSB    = 0;
  localparam int OFF_LSB   = 7;
  localparam int SPEED_LSB = 14;

  // Default level table: on/off/rpm packed
  localparam logic [ENTRY_W-1:0] RESET_TABLE [REG_COUNT] = '{
    30'd640,      30'd35717790, 30'd43915057, 30'd54073653,
    30'd61610810, 30'd69148095, 30'd76357700, 30'd80290635
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } state_t;

  typedef enum logic [1:0] {
    DIR_STAY,
    DIR_DOWN,
    DIR_UP
  } dir_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_done;
    logic slot_free;
  } status_t;

endpackage

### rtl/core/fan_level_hysteresis_select_unit.sv
// Top level of the fan level hysteresis select unit.
// Depends on flhs_pkg, flhs_ctrl and flhs_datapath.
//
// Usage:
//   Input channel in_valid/in_ready carries demand_pct (percent, 7 bits).
//   Output channel out_valid/out_ready carries speed_rpm and level_index.
//   Level table entries are written through cfg_we/cfg_index/cfg_data
//   (on point 6:0, off point 13:7, speed 29:14) while the unit is idle.
//   Each transfer in gives exactly one result.
//   The transfer latches the item, the walk steps through 0 to 7 levels,
//   then the commit loads the output register and raises out_valid.
//   The walk steps one level per cycle through the table lookup at the
//   cursor; a new item is taken only after the previous one is committed.
//   in_ready rises again in the cycle after the commit.
//   Reset loads the default level table, selects level 0, clears the stored
//   demand and drops out_valid.
//   When the receiver stalls, the result waits in the output register; the
//   next item is still taken and walked, then held until the slot frees.
`timescale 1ns / 1ps

module fan_level_hysteresis_select_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [flhs_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [flhs_pkg::ENTRY_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [flhs_pkg::DEMAND_W-1:0] demand_pct,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [flhs_pkg::SPEED_W-1:0]  speed_rpm,
  output logic [flhs_pkg::LEVEL_W-1:0]  level_index
);
  import flhs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing
  flhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Table, walk and output register
  flhs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .demand_pct  (demand_pct),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .speed_rpm   (speed_rpm),
    .level_index (level_index),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

### rtl/core/flhs_datapath.sv
// Datapath: level table registers, hysteresis walk cursor, committed state
// and the output register. Depends on flhs_pkg.
`timescale 1ns / 1ps

module flhs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [flhs_pkg::INDEX_W-1:0]      cfg_index,
  input  logic [flhs_pkg::ENTRY_W-1:0]      cfg_data,
  input  logic [flhs_pkg::DEMAND_W-1:0]     demand_pct,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [flhs_pkg::SPEED_W-1:0]      speed_rpm,
  output logic [flhs_pkg::LEVEL_W-1:0]      level_index,
  input  flhs_pkg::cmd_t                    cmd,
  output flhs_pkg::status_t                 status
);
  import flhs_pkg::*;

  logic [ENTRY_W-1:0]  entry [REG_COUNT];
  logic [LEVEL_W-1:0]  active_level;
  logic [DEMAND_W-1:0] last_demand;
  logic [DEMAND_W-1:0] demand_q;
  logic [LEVEL_W-1:0]  level;
  logic [CUR_W-1:0]    cursor;
  dir_t                dir;

  logic [LEVEL_W-1:0]  start_level;
  logic [INDEX_W-1:0]  sel;
  logic [DEMAND_W-1:0] on_pt;
  logic [DEMAND_W-1:0] off_pt;
  logic                down_go;
  logic                up_go;

  // Saturate the stored level into the table
  assign start_level = ({1'b0, active_level} >= CUR_W'(LEVEL_COUNT))
                       ? LEVEL_W'(LEVEL_COUNT - 1) : active_level;

  // Look up the thresholds at the cursor
  assign sel     = cursor[INDEX_W-1:0];
  assign on_pt   = entry[sel][ON_LSB +: DEMAND_W];
  assign off_pt  = entry[sel][OFF_LSB +: DEMAND_W];
  assign down_go = (demand_q <= off_pt) && (cursor != '0);
  assign up_go   = (cursor < CUR_W'(LEVEL_COUNT)) && (demand_q >= on_pt);

  always_comb begin
    case (dir)
      DIR_DOWN: status.walk_done = !down_go;
      DIR_UP:   status.walk_done = !up_go;
      default:  status.walk_done = 1'b1;
    endcase
    status.slot_free = !out_valid || out_ready;
  end

  // Write the level table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        entry[i] <= RESET_TABLE[i];
      end
    end else if (cfg_we) begin
      entry[cfg_index] <= cfg_data;
    end
  end

  // Latch the item and advance the walk one level per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      demand_q <= demand_pct;
      level    <= start_level;
      if (demand_pct < last_demand) begin
        dir    <= DIR_DOWN;
        cursor <= {1'b0, start_level};
      end else if (demand_pct > last_demand) begin
        dir    <= DIR_UP;
        cursor <= {1'b0, start_level} + CUR_W'(1);
      end else begin
        dir    <= DIR_STAY;
        cursor <= {1'b0, start_level};
      end
    end else if (cmd.step) begin
      case (dir)
        DIR_DOWN: begin
          level  <= sel - LEVEL_W'(1);
          cursor <= cursor - CUR_W'(1);
        end
        DIR_UP: begin
          level  <= sel;
          cursor <= cursor + CUR_W'(1);
        end
        default: begin
          level <= level;
        end
      endcase
    end
  end

  // Commit the selected level
  always_ff @(posedge clk) begin
    if (rst) begin
      active_level <= '0;
      last_demand  <= '0;
    end else if (cmd.commit) begin
      active_level <= level;
      last_demand  <= demand_q;
    end
  end

  // Output register: holds a result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      speed_rpm   <= entry[level][SPEED_LSB +: SPEED_W];
      level_index <= level;
    end
  end

endmodule

### rtl/core/flhs_ctrl.sv
// Controller: sequences accept, level walk and result commit.
// Depends on flhs_pkg.
`timescale 1ns / 1ps

module flhs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  flhs_pkg::status_t status,
  output flhs_pkg::cmd_t    cmd
);
  import flhs_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!status.walk_done) begin
          cmd.step = 1'b1;
        end else if (status.slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (status.slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/flhs_checker.sv
// Port-level checker for the fan level hysteresis select unit, and its bind.
// Depends on fan_level_hysteresis_select_unit_defines.svh.
`timescale 1ns / 1ps
`include "fan_level_hysteresis_select_unit_defines.svh"

module flhs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] speed_rpm,
  input logic [2:0]  level_index
);

  // Stalled result holds
  `FLHS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(speed_rpm) && $stable(level_index), "stalled result changed")

  // Reset leaves the unit empty and ready
  `FLHS_ASSERT_RST(a_reset_empty, rst, !out_valid && in_ready, "not empty after reset")

  // An accepted item leaves the unit busy in the cycle after the transfer
  `FLHS_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after transfer")

  // A new result appears only as the unit goes idle
  `FLHS_ASSERT_NOW(a_commit_idle, $rose(out_valid), in_ready, "result while busy")

endmodule

bind fan_level_hysteresis_select_unit flhs_checker u_flhs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .speed_rpm   (speed_rpm),
  .level_index (level_index)
);

### sim/fan_level_hysteresis_select_unit_tb.sv
// Testbench for the fan level hysteresis select unit: random and directed demand
// against a built-in level walk predictor, over several level tables.
// Depends on flhs_pkg and fan_level_hysteresis_select_unit.
`timescale 1ns / 1ps

module fan_level_hysteresis_select_unit_tb;
  import flhs_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;
  localparam int LONG_HOLD     = 120;

  typedef enum int {
    TBL_ORDERED,
    TBL_ALL_ZERO,
    TBL_ALL_ONES,
    TBL_RAW
  } table_kind_t;

  typedef struct {
    logic [SPEED_W-1:0] speed;
    logic [LEVEL_W-1:0] level;
  } fan_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [INDEX_W-1:0]  cfg_index = '0;
  logic [ENTRY_W-1:0]  cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [DEMAND_W-1:0] demand_pct = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SPEED_W-1:0]  speed_rpm;
  logic [LEVEL_W-1:0]  level_index;

  // Predictor state: level table copy, selected level and previous demand
  logic [ENTRY_W-1:0]  level_tbl [REG_COUNT];
  logic [LEVEL_W-1:0]  cur_level;
  logic [DEMAND_W-1:0] prev_demand;

  logic [DEMAND_W-1:0] demand_backlog [$];
  fan_result_t         level_results_due [$];
  int                  last_queued = 0;
  int                  demands_taken = 0;
  int                  results_seen = 0;
  int                  mismatches = 0;
  int                  cycle_count = 0;
  int                  hold_left = 0;
  bit                  long_hold_done = 1'b0;

  fan_level_hysteresis_select_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .demand_pct  (demand_pct),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .speed_rpm   (speed_rpm),
    .level_index (level_index)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Walk the level table for one demand and queue the result it gives
  function automatic void walk_levels(input logic [DEMAND_W-1:0] demand);
    int          lvl;
    int          idx;
    fan_result_t res;
    lvl = cur_level;
    if (lvl >= LEVEL_COUNT) lvl = LEVEL_COUNT - 1;
    if (demand < prev_demand) begin
      idx = lvl + 1;
      while (idx > 0 && demand <= level_tbl[idx-1][OFF_LSB +: DEMAND_W]) begin
        lvl = (idx >= 2) ? idx - 2 : 0;
        idx--;
      end
    end else if (demand > prev_demand) begin
      idx = lvl + 1;
      while (idx < LEVEL_COUNT && demand >= level_tbl[idx][ON_LSB +: DEMAND_W]) begin
        lvl = idx;
        idx++;
      end
    end
    cur_level   = lvl[LEVEL_W-1:0];
    prev_demand = demand;
    res.speed   = level_tbl[cur_level][SPEED_LSB +: SPEED_W];
    res.level   = cur_level;
    level_results_due.push_back(res);
  endfunction

  // Mostly slow drifts and repeats, some jumps, a few values past 100
  function automatic int next_demand(input int prev);
    int roll;
    int val;
    roll = $urandom_range(99);
    if (roll < 55) val = prev + $urandom_range(12) - 6;
    else if (roll < 70) val = prev;
    else if (roll < 90) val = $urandom_range(100);
    else val = $urandom_range(127);
    if (val < 0) val = 0;
    if (val > 127) val = 127;
    return val;
  endfunction

  task automatic queue_random(input int count);
    for (int n = 0; n < count; n++) begin
      last_queued = next_demand(last_queued);
      demand_backlog.push_back(last_queued[DEMAND_W-1:0]);
    end
  endtask

  // Hold until every item is taken, every result is in and the block has settled
  task automatic wait_drained();
    @(posedge clk);
    while (demand_backlog.size() != 0 || in_valid || level_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Rewrite the whole level table, one register per cycle
  task automatic write_table(input table_kind_t kind);
    logic [ENTRY_W-1:0] entry;
    int                 on_pt;
    int                 off_pt;
    int                 speed;
    int                 prev_on;
    prev_on = 0;
    for (int i = 0; i < REG_COUNT; i++) begin
      case (kind)
        TBL_ORDERED: begin
          on_pt = (i == 0) ? $urandom_range(10) : prev_on + $urandom_range(15, 1);
          if (on_pt > 127) on_pt = 127;
          off_pt = on_pt - $urandom_range(8);
          if (off_pt < 0) off_pt = 0;
          case ($urandom_range(9))
            0: speed = 0;
            1: speed = 65535;
            default: speed = $urandom_range(65535);
          endcase
          prev_on = on_pt;
          entry = {speed[SPEED_W-1:0], off_pt[DEMAND_W-1:0], on_pt[DEMAND_W-1:0]};
        end
        TBL_ALL_ZERO: entry = '0;
        TBL_ALL_ONES: entry = '1;
        default:      entry = ENTRY_W'($urandom);
      endcase
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= i[INDEX_W-1:0];
      cfg_data  <= entry;
      level_tbl[i] = entry;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender: offer the backlog, take the prediction on each transfer
  always @(posedge clk) begin
    bit quiet;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      quiet = (demands_taken >= 1000 && demands_taken < 1250);
      if (in_valid && in_ready) begin
        walk_levels(demand_pct);
        demands_taken++;
      end
      if (!in_valid || in_ready) begin
        if (demand_backlog.size() != 0 && (quiet || $urandom_range(99) >= 11)) begin
          in_valid   <= 1'b1;
          demand_pct <= demand_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= 250) begin
      out_ready      <= 1'b0;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      out_ready <= (results_seen >= 700 && results_seen < 950) || ($urandom_range(99) >= 11);
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    fan_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (level_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: speed %0d level %0d", speed_rpm, level_index);
      end else begin
        want = level_results_due.pop_front();
        if (speed_rpm !== want.speed || level_index !== want.level) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result %0d: speed %0d level %0d, expected speed %0d level %0d",
                     results_seen, speed_rpm, level_index, want.speed, want.level);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fan_level_hysteresis_select_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < REG_COUNT; i++) level_tbl[i] = RESET_TABLE[i];
    cur_level   = '0;
    prev_demand = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Default table: unchanged demand, full climb, drops at off points, values past 100
    demand_backlog = '{7'd0, 7'd127, 7'd127, 7'd100, 7'd70, 7'd71, 7'd75, 7'd0, 7'd29,
                       7'd30, 7'd5, 7'd6, 7'd49, 7'd47, 7'd46, 7'd58, 7'd53, 7'd101,
                       7'd126, 7'd1, 7'd64, 7'd63, 7'd0, 7'd0, 7'd85};
    last_queued = 85;
    queue_random(375);
    wait_drained();

    write_table(TBL_ORDERED);
    queue_random(350);
    wait_drained();

    // Extremes: every field zero, then every field at its top
    write_table(TBL_ALL_ZERO);
    demand_backlog.push_back(7'd127);
    demand_backlog.push_back(7'd0);
    queue_random(150);
    wait_drained();

    write_table(TBL_ALL_ONES);
    demand_backlog.push_back(7'd127);
    demand_backlog.push_back(7'd0);
    demand_backlog.push_back(7'd127);
    queue_random(150);
    wait_drained();

    write_table(TBL_RAW);
    queue_random(300);
    wait_drained();

    write_table(TBL_ORDERED);
    queue_random(350);
    wait_drained();

    if (mismatches == 0 && level_results_due.size() == 0) begin
      $display("fan_level_hysteresis_select_unit_tb: done, clean");
    end else begin
      $display("fan_level_hysteresis_select_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
